@@ design/i2ctrf_pkg.sv @@
// Shared types and constants for the I2C target register file.
package i2ctrf_pkg;

  typedef enum logic [2:0] {
    EV_RD_MATCH = 3'd0,
    EV_RD_REQ   = 3'd1,
    EV_RD_DONE  = 3'd2,
    EV_WR_MATCH = 3'd3,
    EV_WR_BYTE  = 3'd4,
    EV_STOP     = 3'd5
  } ev_t;

  typedef struct packed {
    ev_t        func;
    logic [7:0] data_in;
  } cmd_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       read_valid;
    logic       led_flip;
  } result_t;

  typedef struct packed {
    logic       wr;
    logic [7:0] ptr;
    logic [7:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic vld;
    logic rd_req;
    logic in_range;
    logic led;
  } stage_t;

  localparam logic [7:0] FILL_BYTE     = 8'hCE;
  localparam logic [1:0] TOGGLE_PERIOD = 2'd3;
  localparam logic [7:0] PTR_MAX       = 8'hFF;

endpackage

@@ design/i2ctrf_ctrl.sv @@
// Bus event decoder holding the pointer, byte count, lock and invalid flag.
module i2ctrf_ctrl
  import i2ctrf_pkg::*;
#(
  parameter int MEM_SIZE  = 128,
  parameter int LOCK_CODE = 255
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_vld,
  input  cmd_t     in_cmd,
  output mem_req_t req,
  output stage_t   stg
);

  logic [7:0] ptr;
  logic [7:0] ptr_next;
  logic [7:0] cnt;
  logic [7:0] cnt_next;
  logic [1:0] mod;
  logic [1:0] mod_next;
  logic       lock;
  logic       lock_next;
  logic       inv;
  logic       inv_next;
  stage_t     stg_next;
  logic [7:0] cnt_inc;
  logic [1:0] mod_inc;
  logic       ptr_in_range;

  assign cnt_inc      = cnt + 8'd1;
  assign mod_inc      = ((cnt == PTR_MAX) || (mod == TOGGLE_PERIOD - 2'd1)) ? 2'd0
                                                                           : mod + 2'd1;
  assign ptr_in_range = ptr < 8'(MEM_SIZE);

  always_comb begin
    ptr_next  = ptr;
    cnt_next  = cnt;
    mod_next  = mod;
    lock_next = lock;
    inv_next  = inv;
    req       = '{wr: 1'b0, ptr: ptr, wdata: in_cmd.data_in};
    stg_next  = '{vld: in_vld, rd_req: 1'b0, in_range: 1'b0, led: 1'b0};
    if (in_vld) begin
      unique case (in_cmd.func)
        EV_RD_REQ: begin
          stg_next.rd_req   = 1'b1;
          stg_next.in_range = ptr_in_range && !lock;
        end
        EV_RD_DONE: begin
          if (ptr != PTR_MAX) begin
            ptr_next = ptr + 8'd1;
          end
        end
        EV_WR_MATCH: begin
          ptr_next = '0;
          cnt_next = '0;
          mod_next = '0;
        end
        EV_WR_BYTE: begin
          cnt_next = cnt_inc;
          mod_next = mod_inc;
          if (cnt_inc > 8'd1) begin
            if (!inv) begin
              if (ptr_in_range) begin
                req.wr   = 1'b1;
                ptr_next = ptr + 8'd1;
              end
            end else if (mod_inc == 2'd0) begin
              stg_next.led = 1'b1;
            end
          end else begin
            ptr_next = in_cmd.data_in;
            if (in_cmd.data_in > 8'(MEM_SIZE)) begin
              inv_next = 1'b1;
              if (in_cmd.data_in == 8'(LOCK_CODE)) begin
                lock_next = 1'b1;
              end
            end else begin
              inv_next = 1'b0;
            end
          end
        end
        EV_STOP: begin
          ptr_next  = '0;
          cnt_next  = '0;
          mod_next  = '0;
          lock_next = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr  <= '0;
      cnt  <= '0;
      mod  <= '0;
      lock <= 1'b0;
      inv  <= 1'b0;
      stg  <= '0;
    end else begin
      ptr  <= ptr_next;
      cnt  <= cnt_next;
      mod  <= mod_next;
      lock <= lock_next;
      inv  <= inv_next;
      stg  <= stg_next;
    end
  end

endmodule

@@ design/i2ctrf_mem.sv @@
// Register memory with per-entry valid bits and a registered read port.
module i2ctrf_mem
  import i2ctrf_pkg::*;
#(
  parameter int MEM_SIZE     = 128,
  parameter int STATUS_INDEX = 0,
  parameter int STATUS_INIT  = 1
) (
  input  logic       clk,
  input  logic       rst,
  input  mem_req_t   req,
  output logic [7:0] q
);

  localparam int AW = (MEM_SIZE > 1) ? $clog2(MEM_SIZE) : 1;

  logic [7:0]          mem [MEM_SIZE];
  logic [MEM_SIZE-1:0] vld;
  logic [AW-1:0]       addr;
  logic                hit;
  logic [7:0]          q_raw;
  logic [7:0]          dflt_q;
  logic                vld_q;

  assign addr = req.ptr[AW-1:0];
  assign hit  = req.ptr < 8'(MEM_SIZE);

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[addr] <= req.wdata;
    end
    if (hit) begin
      q_raw <= mem[addr];
    end
    dflt_q <= (req.ptr == 8'(STATUS_INDEX)) ? 8'(STATUS_INIT) : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (req.wr) begin
        vld[addr] <= 1'b1;
      end
      vld_q <= hit && vld[addr];
    end
  end

  assign q = vld_q ? q_raw : dflt_q;

endmodule

@@ design/i2c_target_register_file_core.sv @@
// Top level of the I2C target register file.
// Pipeline: a command taken at a clock edge is held in the input register, then in
// the control stage register, and its result, marked by done, in the output register.
// Throughput: one command per cycle; busy stays low and the result stage never stalls.
// Reset clears the pointer, byte count, lock, invalid flag and the memory's
// entry valid bits, so every entry reads as zero and the status entry as its preset.
module i2c_target_register_file_core
  import i2ctrf_pkg::*;
#(
  parameter int MEM_SIZE     = 128,
  parameter int LOCK_CODE    = 255,
  parameter int STATUS_INDEX = 0,
  parameter int STATUS_INIT  = 1
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  cmd_t    cmd,
  output logic    done,
  output result_t result
);

  logic       in_vld;
  cmd_t       in_cmd;
  mem_req_t   req;
  stage_t     stg;
  logic [7:0] mem_q;
  result_t    result_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else begin
      in_vld <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    in_cmd <= cmd;
  end

  i2ctrf_ctrl #(
    .MEM_SIZE  (MEM_SIZE),
    .LOCK_CODE (LOCK_CODE)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .in_vld (in_vld),
    .in_cmd (in_cmd),
    .req    (req),
    .stg    (stg)
  );

  i2ctrf_mem #(
    .MEM_SIZE     (MEM_SIZE),
    .STATUS_INDEX (STATUS_INDEX),
    .STATUS_INIT  (STATUS_INIT)
  ) u_mem (
    .clk (clk),
    .rst (rst),
    .req (req),
    .q   (mem_q)
  );

  always_comb begin
    result_next.read_data  = stg.rd_req ? (stg.in_range ? mem_q : FILL_BYTE) : 8'd0;
    result_next.read_valid = stg.rd_req;
    result_next.led_flip   = stg.led;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= stg.vld;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

@@ design/i2ctrf_chk.sv @@
// Port-level assertions for the I2C target register file, bound to the top level.
module i2ctrf_chk
  import i2ctrf_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input cmd_t    cmd,
  input logic    done,
  input result_t result
);

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("Accepted command did not complete after three cycles.");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 3))
    else $error("Result appeared without a matching accepted command.");

  a_read_source: assert property (@(posedge clk) disable iff (rst)
    (done && result.read_valid) |-> ($past(cmd.func, 3) == EV_RD_REQ))
    else $error("Read data returned for a command that was not a read request.");

  a_idle_data: assert property (@(posedge clk) disable iff (rst)
    (done && !result.read_valid) |-> (result.read_data == 8'd0))
    else $error("Read data is nonzero without a read request.");

  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.read_valid && result.led_flip))
    else $error("LED toggle raised together with read data.");

endmodule

bind i2c_target_register_file_core i2ctrf_chk u_chk (.*);

@@ sim/i2ctrf_scoreboard_pkg.sv @@
// Scoreboard class that predicts and checks the register file results.
package i2ctrf_scoreboard_pkg;
  import i2ctrf_pkg::*;

  localparam int RF_MEM_SIZE     = 128;
  localparam int RF_LOCK_CODE    = 255;
  localparam int RF_STATUS_INDEX = 0;
  localparam int RF_STATUS_INIT  = 1;

  class regfile_scoreboard;
    logic [7:0] mem_image [RF_MEM_SIZE];
    logic [7:0] ptr_q;
    logic [7:0] byte_cnt;
    logic       lock_q;
    logic       invalid_q;
    result_t    expected_results [$];
    int         mismatches;

    function new();
      for (int k = 0; k < RF_MEM_SIZE; k++) begin
        mem_image[k] = 8'h00;
      end
      if (RF_STATUS_INDEX < RF_MEM_SIZE) begin
        mem_image[RF_STATUS_INDEX] = 8'(RF_STATUS_INIT);
      end
      ptr_q      = 8'h00;
      byte_cnt   = 8'h00;
      lock_q     = 1'b0;
      invalid_q  = 1'b0;
      mismatches = 0;
    endfunction

    function void note_cmd(cmd_t c);
      result_t r;
      r = '0;
      case (c.func)
        EV_RD_REQ: begin
          r.read_valid = 1'b1;
          if (ptr_q < RF_MEM_SIZE && !lock_q) begin
            r.read_data = mem_image[ptr_q];
          end else begin
            r.read_data = FILL_BYTE;
          end
        end
        EV_RD_DONE: begin
          if (ptr_q != PTR_MAX) begin
            ptr_q = ptr_q + 8'd1;
          end
        end
        EV_WR_MATCH: begin
          ptr_q    = 8'h00;
          byte_cnt = 8'h00;
        end
        EV_WR_BYTE: begin
          byte_cnt = byte_cnt + 8'd1;
          if (byte_cnt > 8'd1) begin
            if (!invalid_q) begin
              if (ptr_q < RF_MEM_SIZE) begin
                mem_image[ptr_q] = c.data_in;
                ptr_q = ptr_q + 8'd1;
              end
            end else if (byte_cnt % TOGGLE_PERIOD == 0) begin
              r.led_flip = 1'b1;
            end
          end else begin
            ptr_q = c.data_in;
            if (ptr_q > RF_MEM_SIZE) begin
              if (ptr_q == RF_LOCK_CODE) begin
                lock_q = 1'b1;
              end
              invalid_q = 1'b1;
            end else begin
              invalid_q = 1'b0;
            end
          end
        end
        EV_STOP: begin
          ptr_q    = 8'h00;
          byte_cnt = 8'h00;
          lock_q   = 1'b0;
        end
        default: begin
        end
      endcase
      expected_results.push_back(r);
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: mismatch: %s", $time, msg);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("result %h with no transfer pending", got));
        return;
      end
      want = expected_results.pop_front();
      if (got.read_data !== want.read_data) begin
        report($sformatf("read_data expected %h actual %h", want.read_data, got.read_data));
      end
      if (got.read_valid !== want.read_valid) begin
        report($sformatf("read_valid expected %b actual %b", want.read_valid,
                         got.read_valid));
      end
      if (got.led_flip !== want.led_flip) begin
        report($sformatf("led_flip expected %b actual %b", want.led_flip,
                         got.led_flip));
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

endpackage

@@ sim/tb.sv @@
// Testbench for the I2C target register file core with directed and random bus events.
module tb;
  import i2ctrf_pkg::*;
  import i2ctrf_scoreboard_pkg::*;

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  cmd_t    cmd;
  logic    done;
  result_t result;

  regfile_scoreboard sb;
  int sent;
  bit quiet;

  i2c_target_register_file_core #(
    .MEM_SIZE     (RF_MEM_SIZE),
    .LOCK_CODE    (RF_LOCK_CODE),
    .STATUS_INDEX (RF_STATUS_INDEX),
    .STATUS_INIT  (RF_STATUS_INIT)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("** i2c_target_register_file_core: FAILED **");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      sb.check_result(result);
    end
  end

  task automatic send(ev_t f, logic [7:0] d);
    int   gap;
    cmd_t c;
    gap = (!quiet && $urandom_range(0, 99) < 12) ? $urandom_range(1, 4) : 0;
    c.func    = f;
    c.data_in = d;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    cmd   <= c;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_cmd(c);
    sent++;
  endtask

  function automatic logic [7:0] pick_pointer();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 8'($urandom_range(0, 127));
    if (r < 70) return 8'($urandom_range(118, 127));
    if (r < 78) return 8'(RF_MEM_SIZE);
    if (r < 85) return 8'($urandom_range(129, 254));
    if (r < 93) return 8'(RF_LOCK_CODE);
    return 8'($urandom);
  endfunction

  task automatic write_txn(int nbytes, logic [7:0] p, bit with_stop);
    send(EV_WR_MATCH, 8'($urandom));
    send(EV_WR_BYTE, p);
    repeat (nbytes) send(EV_WR_BYTE, 8'($urandom));
    if (with_stop) send(EV_STOP, 8'($urandom));
  endtask

  task automatic read_txn(bit set_ptr, logic [7:0] p, int n);
    if (set_ptr) begin
      send(EV_WR_MATCH, 8'($urandom));
      send(EV_WR_BYTE, p);
    end
    send(EV_RD_MATCH, 8'($urandom));
    for (int i = 0; i < n; i++) begin
      send(EV_RD_REQ, 8'($urandom));
      if (i < n - 1 || $urandom_range(0, 1)) send(EV_RD_DONE, 8'($urandom));
    end
    send(EV_STOP, 8'($urandom));
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 4)) begin
      send(ev_t'(3'($urandom_range(0, 7))), 8'($urandom));
    end
  endtask

  initial begin
    int  kind;
    bit  paused;
    bit  long_done;
    rst       = 1'b1;
    start     = 1'b0;
    cmd       = '0;
    quiet     = 1'b0;
    sent      = 0;
    paused    = 1'b0;
    long_done = 1'b0;
    sb        = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Status entry, then writes that run past the top of memory.
    send(EV_RD_MATCH, 8'h00);
    send(EV_RD_REQ, 8'hFF);
    send(EV_RD_DONE, 8'h00);
    send(EV_RD_REQ, 8'h00);
    send(EV_WR_MATCH, 8'h00);
    send(EV_WR_BYTE, 8'd126);
    send(EV_WR_BYTE, 8'hFF);
    send(EV_WR_BYTE, 8'h00);
    send(EV_WR_BYTE, 8'hAA);
    send(EV_STOP, 8'h00);
    // Read back across the end of memory.
    send(EV_WR_MATCH, 8'h00);
    send(EV_WR_BYTE, 8'd126);
    send(EV_RD_MATCH, 8'h00);
    send(EV_RD_REQ, 8'h00);
    send(EV_RD_DONE, 8'h00);
    send(EV_RD_REQ, 8'h00);
    send(EV_RD_DONE, 8'h00);
    send(EV_RD_REQ, 8'h00);
    // Lock code, LED toggle, locked read and pointer saturation.
    send(EV_WR_MATCH, 8'h00);
    send(EV_WR_BYTE, 8'(RF_LOCK_CODE));
    send(EV_WR_BYTE, 8'h55);
    send(EV_WR_BYTE, 8'hA5);
    send(EV_RD_REQ, 8'h00);
    send(EV_RD_DONE, 8'h00);
    send(EV_RD_DONE, 8'h00);
    send(EV_STOP, 8'h00);
    // A pointer equal to the memory size stays valid but reads the fill byte.
    send(EV_WR_MATCH, 8'h00);
    send(EV_WR_BYTE, 8'(RF_MEM_SIZE));
    send(EV_RD_REQ, 8'h00);
    send(ev_t'(3'd6), 8'hFF);
    send(ev_t'(3'd7), 8'h00);
    send(EV_STOP, 8'h00);

    while (sent < 1930) begin
      quiet = (sent >= 700 && sent < 1000);
      if (!paused && sent >= 1100) begin
        paused = 1'b1;
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
      end
      if (!long_done && sent >= 400) begin
        long_done = 1'b1;
        write_txn(300, 8'($urandom_range(129, 254)), 1'b1);
        write_txn(135, 8'h00, 1'b1);
      end
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        write_txn($urandom_range(0, 12), pick_pointer(), $urandom_range(0, 9) != 0);
      end else if (kind < 82) begin
        read_txn($urandom_range(0, 4) != 0, pick_pointer(), $urandom_range(1, 10));
      end else begin
        send_noise();
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("** i2c_target_register_file_core: PASSED **");
    end else begin
      $display("** i2c_target_register_file_core: FAILED **");
    end
    $finish;
  end

endmodule
